/* rtl/dsr_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the diffusion stencil rate unit.
package dsr_pkg;

	localparam int COORD_W = 6;
	localparam int SIZE_W = 7;
	localparam int VAL_W = 32;
	localparam int IDX_W = 18;
	localparam int YZ_W = 13;
	localparam int LIN_W = 21;
	localparam int SXY_W = 14;
	localparam int ACC_W = 36;
	localparam int PROD_W = 53;
	localparam int SUM_W = 54;
	localparam int FIN_W = 55;
	localparam int NB_COUNT = 7;
	localparam int NB_SEL_W = 3;
	localparam int QUEUE_DEPTH = 2;
	localparam int CFG_IDX_W = 3;

	localparam logic [NB_SEL_W-1:0] NB_LAST_2D = 3'd4;
	localparam logic [NB_SEL_W-1:0] NB_LAST_3D = 3'd6;

	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_THREE_DIM = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DIFF_COEFF = 3'd4;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd16;
	localparam logic [VAL_W-1:0] COEFF_RESET = 32'h0001_0000;

	typedef struct packed {
		logic [SIZE_W-1:0] size_x;
		logic [SIZE_W-1:0] size_y;
		logic [SIZE_W-1:0] size_z;
		logic three_dim;
		logic [VAL_W-1:0] diff_coeff;
	} dsr_cfg_t;

	typedef struct packed {
		logic evaluate;
		logic err;
		logic three;
		logic [NB_COUNT-1:0][IDX_W-1:0] idx;
		logic signed [VAL_W-1:0] value;
		logic mark;
		logic signed [VAL_W-1:0] source;
	} dsr_cmd_t;

endpackage

/* rtl/dsr_front.sv */
`timescale 1ns / 1ps
// Front end: accepts requests, computes the point indices and checks the coordinates.
module dsr_front import dsr_pkg::*; #(
	parameter int MAX_POINTS = 4096
) (
	input  logic clk,
	input  logic arst_n,
	input  dsr_cfg_t cfg,
	input  logic in_valid,
	output logic in_ready,
	input  logic in_evaluate,
	input  logic [COORD_W-1:0] in_x,
	input  logic [COORD_W-1:0] in_y,
	input  logic [COORD_W-1:0] in_z,
	input  logic signed [VAL_W-1:0] in_value,
	input  logic in_mark,
	input  logic signed [VAL_W-1:0] in_source,
	output logic q_push,
	output dsr_cmd_t q_cmd,
	input  logic q_full
);

	function automatic logic [LIN_W-1:0] nb_lower(input logic [LIN_W-1:0] lin,
			input logic [COORD_W-1:0] c, input logic [SIZE_W-1:0] n,
			input logic [LIN_W-1:0] stride);
		logic [LIN_W-1:0] r;
		if (n < 7'd2) begin
			r = lin;
		end else if (c != '0) begin
			r = lin - stride;
		end else begin
			r = lin + stride;
		end
		return r;
	endfunction

	function automatic logic [LIN_W-1:0] nb_upper(input logic [LIN_W-1:0] lin,
			input logic [COORD_W-1:0] c, input logic [SIZE_W-1:0] n,
			input logic [LIN_W-1:0] stride);
		logic [LIN_W-1:0] r;
		if (n < 7'd2) begin
			r = lin;
		end else if (SIZE_W'(c) + 7'd1 < n) begin
			r = lin + stride;
		end else begin
			r = lin - stride;
		end
		return r;
	endfunction

	logic advance;
	logic v_s1, v_s2;
	logic evaluate_s1, evaluate_s2;
	logic err_s1, err_s2;
	logic [COORD_W-1:0] x_s1, y_s1, z_s1, x_s2, y_s2, z_s2;
	logic [YZ_W-1:0] yz_s1;
	logic [LIN_W-1:0] lin_s2;
	logic signed [VAL_W-1:0] value_s1, value_s2, source_s1, source_s2;
	logic mark_s1, mark_s2;
	logic [SXY_W-1:0] sxy_q;
	logic coord_err;
	logic [YZ_W-1:0] yz_prod;
	logic [NB_COUNT-1:0][LIN_W-1:0] nb;
	logic [NB_COUNT-1:0] oob;
	logic item_err;

	assign advance = !(v_s2 && q_full);
	assign in_ready = advance;

	assign coord_err = ({1'b0, in_x} >= cfg.size_x) || ({1'b0, in_y} >= cfg.size_y) ||
		({1'b0, in_z} >= cfg.size_z);
	assign yz_prod = YZ_W'(cfg.size_y) * YZ_W'(in_z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (advance) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		sxy_q <= SXY_W'(cfg.size_x) * SXY_W'(cfg.size_y);
		if (advance) begin
			evaluate_s1 <= in_evaluate;
			err_s1 <= coord_err;
			x_s1 <= in_x;
			y_s1 <= in_y;
			z_s1 <= in_z;
			yz_s1 <= yz_prod + YZ_W'(in_y);
			value_s1 <= in_value;
			mark_s1 <= in_mark;
			source_s1 <= in_source;
			evaluate_s2 <= evaluate_s1;
			err_s2 <= err_s1;
			x_s2 <= x_s1;
			y_s2 <= y_s1;
			z_s2 <= z_s1;
			lin_s2 <= LIN_W'(cfg.size_x) * LIN_W'(yz_s1) + LIN_W'(x_s1);
			value_s2 <= value_s1;
			mark_s2 <= mark_s1;
			source_s2 <= source_s1;
		end
	end

	always_comb begin
		nb[0] = lin_s2;
		nb[1] = nb_lower(lin_s2, x_s2, cfg.size_x, LIN_W'(1));
		nb[2] = nb_upper(lin_s2, x_s2, cfg.size_x, LIN_W'(1));
		nb[3] = nb_lower(lin_s2, y_s2, cfg.size_y, LIN_W'(cfg.size_x));
		nb[4] = nb_upper(lin_s2, y_s2, cfg.size_y, LIN_W'(cfg.size_x));
		nb[5] = nb_lower(lin_s2, z_s2, cfg.size_z, LIN_W'(sxy_q));
		nb[6] = nb_upper(lin_s2, z_s2, cfg.size_z, LIN_W'(sxy_q));
		for (int i = 0; i < NB_COUNT; i++) begin
			oob[i] = nb[i] >= LIN_W'(MAX_POINTS);
		end
	end

	assign item_err = err_s2 || oob[0] ||
		(evaluate_s2 && ((|oob[4:1]) || (cfg.three_dim && (|oob[6:5]))));

	assign q_push = v_s2 && !q_full;

	always_comb begin
		q_cmd.evaluate = evaluate_s2;
		q_cmd.err = item_err;
		q_cmd.three = cfg.three_dim;
		for (int i = 0; i < NB_COUNT; i++) begin
			q_cmd.idx[i] = nb[i][IDX_W-1:0];
		end
		q_cmd.value = value_s2;
		q_cmd.mark = mark_s2;
		q_cmd.source = source_s2;
	end

endmodule

/* rtl/dsr_queue.sv */
`timescale 1ns / 1ps
// Short command queue between the front end and the back end.
module dsr_queue import dsr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  dsr_cmd_t push_cmd,
	output logic full,
	output logic head_valid,
	output dsr_cmd_t head_cmd,
	input  logic pop
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	dsr_cmd_t entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push, do_pop;

	assign full = count_q == CNT_W'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_cmd = entries_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> count_q < CNT_W'(QUEUE_DEPTH))
		else $error("Command pushed into a full queue.");

endmodule

/* rtl/dsr_back.sv */
`timescale 1ns / 1ps
// Back end: grid memory, stencil accumulation, scaling, saturation and result register.
module dsr_back import dsr_pkg::*; #(
	parameter int MAX_POINTS = 4096
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [VAL_W-1:0] diff_coeff,
	input  logic q_valid,
	input  dsr_cmd_t q_cmd,
	output logic q_pop,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [VAL_W-1:0] out_rate,
	output logic out_status,
	output logic out_was_fixed
);

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam logic signed [FIN_W-1:0] SAT_MAX = 55'sd2147483647;
	localparam logic signed [FIN_W-1:0] SAT_MIN = -55'sd2147483648;

	typedef enum logic [2:0] {ST_IDLE, ST_READ, ST_MUL, ST_SUM, ST_DONE} state_t;

	logic [VAL_W:0] grid_mem [MAX_POINTS];
	logic [VAL_W:0] rd_data_q;

	state_t state_q;
	dsr_cmd_t cur_q;
	logic [NB_SEL_W-1:0] cnt_q, lat_q;
	logic signed [ACC_W-1:0] acc_q;
	logic mark_q;
	logic signed [PROD_W-1:0] p_hi_q, p_lo_q;
	logic signed [SUM_W-1:0] sum_q;
	logic out_valid_q, out_status_q, out_fixed_q;
	logic signed [VAL_W-1:0] out_rate_q;

	logic [NB_SEL_W-1:0] last_sel, rd_sel;
	logic rd_en, mem_we;
	logic [AW-1:0] rd_addr, mem_wa;
	logic signed [ACC_W-1:0] rd_ext, c4, c6, acc_nx;
	logic signed [16:0] chi_s, clo_s;
	logic signed [FIN_W-1:0] fin;
	logic signed [VAL_W-1:0] sat;
	logic zero_rate;
	logic out_load;

	assign last_sel = cur_q.three ? NB_LAST_3D : NB_LAST_2D;
	assign rd_sel = (cnt_q > last_sel) ? last_sel : cnt_q;

	always_comb begin
		q_pop = 1'b0;
		rd_en = 1'b0;
		mem_we = 1'b0;
		rd_addr = q_cmd.idx[0][AW-1:0];
		mem_wa = q_cmd.idx[0][AW-1:0];
		unique case (state_q)
			ST_IDLE: begin
				q_pop = q_valid;
				if (q_valid && !q_cmd.err) begin
					rd_en = q_cmd.evaluate;
					mem_we = !q_cmd.evaluate;
				end
			end
			ST_READ: begin
				rd_addr = cur_q.idx[rd_sel][AW-1:0];
				rd_en = cnt_q <= last_sel;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			grid_mem[mem_wa] <= {q_cmd.mark, q_cmd.value};
		end
		if (rd_en) begin
			rd_data_q <= grid_mem[rd_addr];
		end
	end

	assign rd_ext = {{(ACC_W - VAL_W){rd_data_q[VAL_W-1]}}, rd_data_q[VAL_W-1:0]};
	assign c4 = rd_ext <<< 2;
	assign c6 = c4 + (rd_ext <<< 1);
	assign acc_nx = (lat_q == '0) ? acc_q - (cur_q.three ? c6 : c4) : acc_q + rd_ext;
	assign chi_s = {1'b0, diff_coeff[31:16]};
	assign clo_s = {1'b0, diff_coeff[15:0]};
	assign fin = FIN_W'(sum_q) + FIN_W'(cur_q.source);
	assign sat = (fin > SAT_MAX) ? VAL_W'(SAT_MAX) :
		(fin < SAT_MIN) ? VAL_W'(SAT_MIN) : fin[VAL_W-1:0];
	assign zero_rate = cur_q.err || !cur_q.evaluate || mark_q;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && !out_ready);
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						cur_q <= q_cmd;
						mark_q <= 1'b0;
						acc_q <= '0;
						cnt_q <= NB_SEL_W'(1);
						lat_q <= '0;
						state_q <= (q_cmd.evaluate && !q_cmd.err) ? ST_READ : ST_DONE;
					end
				end
				ST_READ: begin
					acc_q <= acc_nx;
					if (lat_q == '0) begin
						mark_q <= rd_data_q[VAL_W];
					end
					if (cnt_q <= last_sel) begin
						lat_q <= cnt_q;
						cnt_q <= cnt_q + 1'b1;
					end
					if (lat_q == last_sel) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					p_hi_q <= acc_q * chi_s;
					p_lo_q <= acc_q * clo_s;
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					sum_q <= SUM_W'(p_hi_q) + SUM_W'((p_lo_q + 53'sd32768) >>> 16);
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						out_status_q <= cur_q.err;
						out_fixed_q <= !cur_q.err && cur_q.evaluate && mark_q;
						out_rate_q <= zero_rate ? '0 : sat;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_rate = out_rate_q;
	assign out_status = out_status_q;
	assign out_was_fixed = out_fixed_q;

	a_read_only_for_eval: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |-> cur_q.evaluate && !cur_q.err)
		else $error("Grid read sequence started for a write or a failed request.");

	a_pop_starts_work: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> state_q != ST_IDLE)
		else $error("Popped request was not taken up.");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("Result appeared outside the completion state.");

endmodule

/* rtl/diffusion_stencil_rate_unit.sv */
`timescale 1ns / 1ps
// Top level of the diffusion stencil rate unit: configuration registers and stream ports.
//
// Channel     Direction  Handshake                      Contents
// s_axis      in         s_axis_tvalid / s_axis_tready  one write or evaluate request
// m_axis      out        m_axis_tvalid / m_axis_tready  one result per request
// cfg         in         cfg_we                         register write, no read-back
//
// An evaluate request makes seven grid reads in 3D mode and five in 2D mode, all on the
// single memory read port, then the coefficient multiply, rounding and saturation.
// Writes and rejected requests skip the grid reads; the front end stages are registered.
// Reset sets the grid size to 16 x 16 x 16, 3D mode and a coefficient of 1.0; the grid
// memory is not cleared.
// Requests keep being accepted while a result waits on m_axis, until the queue fills.
module diffusion_stencil_rate_unit import dsr_pkg::*; #(
	parameter int MAX_POINTS = 4096
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// pos_x[5:0], pos_y[11:6], pos_z[17:12], point_value[49:18], fixed_mark[50],
	// source_term[82:51], zero padding[87:83]
	input  logic [87:0] s_axis_tdata,
	// action[0]
	input  logic s_axis_tuser,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// rate[31:0], status[32], was_fixed[33], zero padding[39:34]
	output logic [39:0] m_axis_tdata,
	input  logic cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [VAL_W-1:0] cfg_data
);

	dsr_cfg_t cfg_q;
	logic q_push, q_full, q_valid, q_pop;
	dsr_cmd_t push_cmd, head_cmd;
	logic signed [VAL_W-1:0] rate;
	logic status, was_fixed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.size_x <= SIZE_RESET;
			cfg_q.size_y <= SIZE_RESET;
			cfg_q.size_z <= SIZE_RESET;
			cfg_q.three_dim <= 1'b1;
			cfg_q.diff_coeff <= COEFF_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SIZE_X: cfg_q.size_x <= cfg_data[SIZE_W-1:0];
				CFG_SIZE_Y: cfg_q.size_y <= cfg_data[SIZE_W-1:0];
				CFG_SIZE_Z: cfg_q.size_z <= cfg_data[SIZE_W-1:0];
				CFG_THREE_DIM: cfg_q.three_dim <= cfg_data[0];
				CFG_DIFF_COEFF: cfg_q.diff_coeff <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	dsr_front #(
		.MAX_POINTS(MAX_POINTS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_evaluate(s_axis_tuser),
		.in_x(s_axis_tdata[5:0]),
		.in_y(s_axis_tdata[11:6]),
		.in_z(s_axis_tdata[17:12]),
		.in_value(s_axis_tdata[49:18]),
		.in_mark(s_axis_tdata[50]),
		.in_source(s_axis_tdata[82:51]),
		.q_push(q_push),
		.q_cmd(push_cmd),
		.q_full(q_full)
	);

	dsr_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_cmd(push_cmd),
		.full(q_full),
		.head_valid(q_valid),
		.head_cmd(head_cmd),
		.pop(q_pop)
	);

	dsr_back #(
		.MAX_POINTS(MAX_POINTS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.diff_coeff(cfg_q.diff_coeff),
		.q_valid(q_valid),
		.q_cmd(head_cmd),
		.q_pop(q_pop),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_rate(rate),
		.out_status(status),
		.out_was_fixed(was_fixed)
	);

	assign m_axis_tdata = {6'd0, was_fixed, status, rate};

endmodule
